// ===== rtl/lacm_pkg.sv =====
// ----------------------------------------------------------------------------
// lacm_pkg
// shared types and constants of the look-at camera matrix builder
// ----------------------------------------------------------------------------
package lacm_pkg;

	localparam int NORM_BITS = 30;
	localparam int SUM_W     = 2 * NORM_BITS + 2;
	localparam int ROOT_W    = NORM_BITS + 1;

	localparam logic [1:0] ROW_FIRST = 2'd0;
	localparam logic [1:0] ROW_LAST  = 2'd3;

	typedef enum logic [6:0] {
		PH_IDLE   = 7'b0000001,
		PH_FRONT  = 7'b0000010,
		PH_HINT   = 7'b0000100,
		PH_CROSS1 = 7'b0001000,
		PH_RIGHT  = 7'b0010000,
		PH_CROSS2 = 7'b0100000,
		PH_EMIT   = 7'b1000000
	} phase_t;

	typedef enum logic [3:0] {
		ST_MAG  = 4'b0001,
		ST_SQ   = 4'b0010,
		ST_ROOT = 4'b0100,
		ST_DIV  = 4'b1000
	} sub_t;

endpackage

// ===== rtl/lacm_front.sv =====
// ----------------------------------------------------------------------------
// lacm_front
// input stage: takes a beat, forms the saturated position minus target
// difference, flags a zero difference and pushes the item into the queue
// ----------------------------------------------------------------------------
module lacm_front import lacm_pkg::*; #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [COORD_WIDTH-1:0] pos_x,
	input  logic [COORD_WIDTH-1:0] pos_y,
	input  logic [COORD_WIDTH-1:0] pos_z,
	input  logic [COORD_WIDTH-1:0] tgt_x,
	input  logic [COORD_WIDTH-1:0] tgt_y,
	input  logic [COORD_WIDTH-1:0] tgt_z,
	input  logic [COORD_WIDTH-1:0] hint_x,
	input  logic [COORD_WIDTH-1:0] hint_y,
	input  logic [COORD_WIDTH-1:0] hint_z,
	output logic                   push,
	output logic [9*COORD_WIDTH:0] push_data,
	input  logic                   queue_full
);

	localparam int W = COORD_WIDTH;

	logic [2:0][W-1:0] pos_in, tgt_in, hint_in, diff;
	logic              accept;
	logic              v_s1;
	logic [2:0][W-1:0] d_s1, pos_s1, hint_s1;
	logic              dz_s1;

	assign pos_in  = {pos_z, pos_y, pos_x};
	assign tgt_in  = {tgt_z, tgt_y, tgt_x};
	assign hint_in = {hint_z, hint_y, hint_x};

	// saturating difference per component
	always_comb begin
		logic signed [W:0] t;
		for (int i = 0; i < 3; i++) begin
			t = $signed({pos_in[i][W-1], pos_in[i]}) - $signed({tgt_in[i][W-1], tgt_in[i]});
			if (t[W] != t[W-1])
				diff[i] = t[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
			else
				diff[i] = t[W-1:0];
		end
	end

	assign push      = v_s1 && !queue_full;
	assign in_stall  = v_s1 && queue_full;
	assign accept    = in_valid && !in_stall;
	assign push_data = {dz_s1, hint_s1, pos_s1, d_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			d_s1    <= diff;
			pos_s1  <= pos_in;
			hint_s1 <= hint_in;
			dz_s1   <= (diff == '0);
		end
	end

endmodule

// ===== rtl/lacm_queue.sv =====
// ----------------------------------------------------------------------------
// lacm_queue
// two-entry queue between the input stage and the matrix engine
// ----------------------------------------------------------------------------
module lacm_queue import lacm_pkg::*; #(
	parameter int DATA_W = 289
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	output logic              full,
	output logic              pop_valid,
	input  logic              pop,
	output logic [DATA_W-1:0] pop_data
);

	logic [DATA_W-1:0] mem_q [2];
	logic              wr_ptr_q, rd_ptr_q;
	logic [1:0]        count_q;

	assign full      = (count_q == 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

endmodule

// ===== rtl/lacm_back.sv =====
// ----------------------------------------------------------------------------
// lacm_back
// matrix engine: shared normalize sequencer (squares, square root, three
// divider lanes), sequential cross products and the row output register
// ----------------------------------------------------------------------------
module lacm_back import lacm_pkg::*; #(
	parameter int FRAC_BITS   = 16,
	parameter int COORD_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	output logic                   q_pop,
	input  logic [9*COORD_WIDTH:0] q_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [1:0]             row_index,
	output logic [COORD_WIDTH-1:0] col_right,
	output logic [COORD_WIDTH-1:0] col_up,
	output logic [COORD_WIDTH-1:0] col_front,
	output logic [COORD_WIDTH-1:0] col_translate,
	output logic                   last_row,
	output logic                   degenerate
);

	localparam int W    = COORD_WIDTH;
	localparam int F    = FRAC_BITS;
	localparam int UW   = F + 2;
	localparam int MAGW = (W > F + 3) ? W : F + 3;
	localparam int DW   = 2 * UW + 1;
	localparam int CW   = (DW > MAGW) ? DW : MAGW;
	localparam int BW   = $clog2(MAGW + 1);
	localparam int DCW  = $clog2(F + 1);
	localparam logic [63:0]    ONE_WIDE = 64'd1 << F;
	localparam logic [W-1:0]   ONE_FX   = ONE_WIDE[W-1:0];
	localparam logic [SUM_W-1:0] BIT_START = SUM_W'(1) << (SUM_W - 2);

	typedef logic signed [UW-1:0]   unit_t;
	typedef logic signed [MAGW-1:0] vec_t;

	phase_t phase_q;
	sub_t   sub_q;

	vec_t                vec_q   [3];
	logic                neg_q   [3];
	logic [NORM_BITS-1:0] m_q    [3];
	logic [SUM_W-1:0]    sum_q, rad_q, res_q, bit_q;
	logic [ROOT_W:0]     rem_q   [3];
	logic [F:0]          quo_q   [3];
	logic [DCW-1:0]      dcnt_q;
	logic [1:0]          idx_q;
	logic [2:0]          step_q;
	unit_t               front_q [3];
	unit_t               hn_q    [3];
	unit_t               right_q [3];
	vec_t                up_q    [3];
	logic [W-1:0]        pos_q   [3];
	logic [W-1:0]        hint_q  [3];
	logic                degen_q;
	logic signed [CW-1:0] prod_q;

	logic                out_valid_q, last_row_q, degen_out_q;
	logic [1:0]          row_q;
	logic [W-1:0]        right_out_q, up_out_q, front_out_q, trans_out_q;

	// normalize front end
	logic [MAGW-1:0]      mag [3];
	logic [MAGW-1:0]      mx;
	logic [BW-1:0]        blen;
	logic [NORM_BITS-1:0] m_norm [3];

	always_comb begin
		logic [MAGW+NORM_BITS-1:0] wide;
		mx   = '0;
		blen = '0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = vec_q[i][MAGW-1] ? (~vec_q[i] + MAGW'(1)) : vec_q[i];
			if (mag[i] > mx)
				mx = mag[i];
		end
		for (int i = 0; i < MAGW; i++) begin
			if (mx[i])
				blen = BW'(i + 1);
		end
		for (int i = 0; i < 3; i++) begin
			wide      = {mag[i], {NORM_BITS{1'b0}}} >> blen;
			m_norm[i] = wide[NORM_BITS-1:0];
		end
	end

	// sum of squares
	logic [SUM_W-1:0] sq, sum_next;
	always_comb begin
		logic [NORM_BITS-1:0] ms;
		case (idx_q)
			2'd0:    ms = m_q[0];
			2'd1:    ms = m_q[1];
			default: ms = m_q[2];
		endcase
		sq       = SUM_W'(ms) * SUM_W'(ms);
		sum_next = sum_q + sq;
	end

	// square root step
	logic [SUM_W-1:0] trial, rad_next, res_next;
	always_comb begin
		trial = res_q + bit_q;
		if (rad_q >= trial) begin
			rad_next = rad_q - trial;
			res_next = (res_q >> 1) + bit_q;
		end else begin
			rad_next = rad_q;
			res_next = res_q >> 1;
		end
	end

	// divider lanes
	logic [ROOT_W-1:0] len;
	logic              ge      [3];
	logic [ROOT_W:0]   rem_sub [3];
	unit_t             u_res   [3];
	always_comb begin
		logic [F:0]    qf;
		logic [UW-1:0] qe;
		len = res_q[ROOT_W-1:0];
		for (int i = 0; i < 3; i++) begin
			ge[i]      = rem_q[i] >= {1'b0, len};
			rem_sub[i] = ge[i] ? rem_q[i] - {1'b0, len} : rem_q[i];
			qf         = {quo_q[i][F-1:0], ge[i]};
			qe         = {1'b0, qf};
			u_res[i]   = neg_q[i] ? unit_t'(~qe + UW'(1)) : unit_t'(qe);
		end
	end

	// cross product step
	unit_t               ca_i, ca_j, cb_i, cb_j;
	logic [1:0]          ck;
	logic signed [CW-1:0] pm, cdiff, cmag, cres;
	always_comb begin
		logic [1:0] ci, cj;
		logic signed [2*UW-1:0] p_raw;
		ck = step_q[2:1];
		case (ck)
			2'd0:    begin ci = 2'd1; cj = 2'd2; end
			2'd1:    begin ci = 2'd2; cj = 2'd0; end
			default: begin ci = 2'd0; cj = 2'd1; end
		endcase
		if (phase_q == PH_CROSS1) begin
			ca_i = hn_q[ci];    ca_j = hn_q[cj];
			cb_i = front_q[ci]; cb_j = front_q[cj];
		end else begin
			ca_i = front_q[ci]; ca_j = front_q[cj];
			cb_i = right_q[ci]; cb_j = right_q[cj];
		end
		if (!step_q[0])
			p_raw = ca_i * cb_j;
		else
			p_raw = ca_j * cb_i;
		pm    = CW'(p_raw);
		cdiff = prod_q - pm;
		cmag  = cdiff[CW-1] ? -cdiff : cdiff;
		cres  = cdiff[CW-1] ? -(cmag >>> F) : (cmag >>> F);
	end

	// queue item fields
	logic [2:0][W-1:0] qd, qpos, qhint;
	logic              qdz;
	assign {qdz, qhint, qpos, qd} = q_data;

	logic load_ok;
	assign load_ok = !out_valid_q || !out_stall;
	assign q_pop   = (phase_q == PH_IDLE) && q_valid;

	function automatic logic [W-1:0] to_port(input logic signed [CW-1:0] v);
		return v[W-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			sub_q       <= ST_MAG;
			out_valid_q <= 1'b0;
			idx_q       <= 2'd0;
			step_q      <= 3'd0;
			dcnt_q      <= '0;
		end else begin
			if (out_valid_q && !out_stall && phase_q != PH_EMIT)
				out_valid_q <= 1'b0;
			case (phase_q)
				PH_IDLE: begin
					if (q_valid) begin
						phase_q <= PH_FRONT;
						sub_q   <= ST_MAG;
					end
				end
				PH_FRONT, PH_HINT, PH_RIGHT: begin
					case (sub_q)
						ST_MAG: begin
							if (mx == '0) begin
								case (phase_q)
									PH_FRONT: begin
										phase_q <= PH_HINT;
										sub_q   <= ST_MAG;
									end
									PH_HINT: begin
										phase_q <= PH_CROSS1;
										step_q  <= 3'd0;
									end
									default: begin
										phase_q <= PH_CROSS2;
										step_q  <= 3'd0;
									end
								endcase
							end else begin
								sub_q <= ST_SQ;
								idx_q <= 2'd0;
							end
						end
						ST_SQ: begin
							idx_q <= idx_q + 2'd1;
							if (idx_q == 2'd2)
								sub_q <= ST_ROOT;
						end
						ST_ROOT: begin
							if (bit_q[0]) begin
								sub_q  <= ST_DIV;
								dcnt_q <= '0;
							end
						end
						ST_DIV: begin
							dcnt_q <= dcnt_q + DCW'(1);
							if (dcnt_q == DCW'(F)) begin
								case (phase_q)
									PH_FRONT: begin
										phase_q <= PH_HINT;
										sub_q   <= ST_MAG;
									end
									PH_HINT: begin
										phase_q <= PH_CROSS1;
										step_q  <= 3'd0;
									end
									default: begin
										phase_q <= PH_CROSS2;
										step_q  <= 3'd0;
									end
								endcase
							end
						end
						default: sub_q <= ST_MAG;
					endcase
				end
				PH_CROSS1, PH_CROSS2: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd5) begin
						if (phase_q == PH_CROSS1) begin
							phase_q <= PH_RIGHT;
							sub_q   <= ST_MAG;
						end else begin
							phase_q <= PH_EMIT;
							idx_q   <= ROW_FIRST;
						end
					end
				end
				PH_EMIT: begin
					if (load_ok) begin
						out_valid_q <= 1'b1;
						idx_q       <= idx_q + 2'd1;
						if (idx_q == ROW_LAST)
							phase_q <= PH_IDLE;
					end
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			PH_IDLE: begin
				if (q_valid) begin
					for (int i = 0; i < 3; i++) begin
						vec_q[i] <= MAGW'($signed(qd[i]));
						pos_q[i] <= qpos[i];
					end
					degen_q <= qdz;
				end
			end
			PH_FRONT, PH_HINT, PH_RIGHT: begin
				case (sub_q)
					ST_MAG: begin
						for (int i = 0; i < 3; i++) begin
							m_q[i]   <= m_norm[i];
							neg_q[i] <= vec_q[i][MAGW-1];
						end
						sum_q <= '0;
						if (mx == '0) begin
							case (phase_q)
								PH_FRONT: begin
									degen_q <= 1'b1;
									for (int i = 0; i < 3; i++) begin
										front_q[i] <= '0;
										vec_q[i]   <= MAGW'($signed(hint_q[i]));
									end
								end
								PH_HINT: begin
									for (int i = 0; i < 3; i++)
										hn_q[i] <= '0;
								end
								default: begin
									degen_q <= 1'b1;
									for (int i = 0; i < 3; i++)
										right_q[i] <= '0;
								end
							endcase
						end
					end
					ST_SQ: begin
						sum_q <= sum_next;
						if (idx_q == 2'd2) begin
							rad_q <= sum_next;
							res_q <= '0;
							bit_q <= BIT_START;
						end
					end
					ST_ROOT: begin
						rad_q <= rad_next;
						res_q <= res_next;
						bit_q <= bit_q >> 2;
						for (int i = 0; i < 3; i++) begin
							rem_q[i] <= (ROOT_W + 1)'(m_q[i]);
							quo_q[i] <= '0;
						end
					end
					ST_DIV: begin
						for (int i = 0; i < 3; i++) begin
							rem_q[i] <= {rem_sub[i][ROOT_W-1:0], 1'b0};
							quo_q[i] <= {quo_q[i][F-1:0], ge[i]};
						end
						if (dcnt_q == DCW'(F)) begin
							case (phase_q)
								PH_FRONT: begin
									for (int i = 0; i < 3; i++) begin
										front_q[i] <= u_res[i];
										vec_q[i]   <= MAGW'($signed(hint_q[i]));
									end
								end
								PH_HINT: begin
									for (int i = 0; i < 3; i++)
										hn_q[i] <= u_res[i];
								end
								default: begin
									for (int i = 0; i < 3; i++)
										right_q[i] <= u_res[i];
								end
							endcase
						end
					end
					default: sum_q <= sum_q;
				endcase
			end
			PH_CROSS1, PH_CROSS2: begin
				if (!step_q[0]) begin
					prod_q <= pm;
				end else if (phase_q == PH_CROSS1) begin
					vec_q[ck] <= cres[MAGW-1:0];
				end else begin
					up_q[ck] <= cres[MAGW-1:0];
				end
			end
			PH_EMIT: begin
				if (load_ok) begin
					row_q       <= idx_q;
					last_row_q  <= (idx_q == ROW_LAST);
					degen_out_q <= degen_q;
					if (idx_q == ROW_LAST || degen_q) begin
						right_out_q <= '0;
						up_out_q    <= '0;
						front_out_q <= '0;
					end else begin
						right_out_q <= to_port(CW'(right_q[idx_q]));
						up_out_q    <= to_port(CW'(up_q[idx_q]));
						front_out_q <= to_port(CW'(front_q[idx_q]));
					end
					if (idx_q == ROW_LAST)
						trans_out_q <= ONE_FX;
					else
						trans_out_q <= pos_q[idx_q];
				end
			end
			default: sum_q <= sum_q;
		endcase
	end

	// hint held with the item until its normalize pass
	always_ff @(posedge clk) begin
		if (phase_q == PH_IDLE && q_valid) begin
			for (int i = 0; i < 3; i++)
				hint_q[i] <= qhint[i];
		end
	end

	assign out_valid     = out_valid_q;
	assign row_index     = row_q;
	assign col_right     = right_out_q;
	assign col_up        = up_out_q;
	assign col_front     = front_out_q;
	assign col_translate = trans_out_q;
	assign last_row      = last_row_q;
	assign degenerate    = degen_out_q;

endmodule

// ===== rtl/look_at_camera_matrix.sv =====
// ----------------------------------------------------------------------------
// look_at_camera_matrix
// builds a look-at view matrix from camera position, target and up hint
// ----------------------------------------------------------------------------
// One input beat yields four row beats, rows 0 to 3 in order. After it
// fetches the item, the engine runs three normalize passes, one per vector
// (magnitude and shift, squares, one square-root bit per cycle, one quotient
// bit per cycle in three divider lanes), then two sequential cross products,
// and then emits the rows; a zero-length vector ends its pass after the
// magnitude step. The shared square-root and divider sequencer sets the
// rate. Input beats are taken into a two-entry queue while the engine works
// on an earlier item, and rows wait in an output register.
module look_at_camera_matrix import lacm_pkg::*; #(
	parameter int FRAC_BITS   = 16,
	parameter int COORD_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [COORD_WIDTH-1:0] pos_x,
	input  logic [COORD_WIDTH-1:0] pos_y,
	input  logic [COORD_WIDTH-1:0] pos_z,
	input  logic [COORD_WIDTH-1:0] tgt_x,
	input  logic [COORD_WIDTH-1:0] tgt_y,
	input  logic [COORD_WIDTH-1:0] tgt_z,
	input  logic [COORD_WIDTH-1:0] hint_x,
	input  logic [COORD_WIDTH-1:0] hint_y,
	input  logic [COORD_WIDTH-1:0] hint_z,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [1:0]             row_index,
	output logic [COORD_WIDTH-1:0] col_right,
	output logic [COORD_WIDTH-1:0] col_up,
	output logic [COORD_WIDTH-1:0] col_front,
	output logic [COORD_WIDTH-1:0] col_translate,
	output logic                   last_row,
	output logic                   degenerate
);

	localparam int DATA_W = 9 * COORD_WIDTH + 1;

	logic              push, full, pop_valid, pop;
	logic [DATA_W-1:0] push_data, pop_data;

	lacm_front #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.tgt_x     (tgt_x),
		.tgt_y     (tgt_y),
		.tgt_z     (tgt_z),
		.hint_x    (hint_x),
		.hint_y    (hint_y),
		.hint_z    (hint_z),
		.push      (push),
		.push_data (push_data),
		.queue_full(full)
	);

	lacm_queue #(
		.DATA_W(DATA_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (full),
		.pop_valid(pop_valid),
		.pop      (pop),
		.pop_data (pop_data)
	);

	lacm_back #(
		.FRAC_BITS  (FRAC_BITS),
		.COORD_WIDTH(COORD_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (pop_valid),
		.q_pop        (pop),
		.q_data       (pop_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.row_index    (row_index),
		.col_right    (col_right),
		.col_up       (col_up),
		.col_front    (col_front),
		.col_translate(col_translate),
		.last_row     (last_row),
		.degenerate   (degenerate)
	);

endmodule

// ===== rtl/lacm_checker.sv =====
// ----------------------------------------------------------------------------
// lacm_checker
// port-level checks on the row stream of the matrix builder
// ----------------------------------------------------------------------------
module lacm_checker import lacm_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] row_index,
	input logic       last_row,
	input logic       degenerate
);

	// stalled beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(row_index) && $stable(degenerate))
		else $error("stalled row beat changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_row == (row_index == ROW_LAST)))
		else $error("last_row does not match row_index");

	// rows of one matrix follow back to back
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_row |=>
			out_valid && (row_index == $past(row_index) + 2'd1))
		else $error("row sequence broken");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_row |=> degenerate == $past(degenerate))
		else $error("degenerate flag changed within a matrix");

endmodule

bind look_at_camera_matrix lacm_checker u_lacm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.row_index (row_index),
	.last_row  (last_row),
	.degenerate(degenerate)
);
